// ----- rtl/ramst_pkg.sv -----
// ramst_pkg: shared types and constants for the range add / min search block
// used by ramst_ctrl, ramst_dp and range_add_min_search_tree
package ramst_pkg;

  localparam int unsigned ValW   = 14;
  localparam int unsigned AmtW   = 13;
  localparam int unsigned PosW   = 11;
  localparam int unsigned CmdW   = 2;
  localparam int          ValMax = 8191;
  localparam int          ValMin = -8192;

  typedef enum logic [CmdW-1:0] {
    CMD_INIT   = 2'd0,
    CMD_ADD    = 2'd1,
    CMD_SEARCH = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_e;

  // commands from controller to datapath
  typedef struct packed {
    logic load;      // capture input word, set pointer and end
    logic wr;        // write entry at pointer
    logic step_up;
    logic step_dn;
    logic set_hit;   // answer = pointer + 1
    logic set_miss;  // answer = 1
    logic out_load;  // move answer to output register
  } ramst_ctl_t;

  // status from datapath to controller
  typedef struct packed {
    cmd_e cmd;
    logic empty;     // add range is empty
    logic at_end;
    logic hit;       // read entry below threshold
    logic out_free;
  } ramst_sts_t;

endpackage

// ----- rtl/range_add_min_search_tree.sv -----
// range_add_min_search_tree: top level, controller plus datapath
// depends on ramst_pkg, ramst_ctrl, ramst_dp
//
// usage: one signed 14-bit value per position 1..n, n = size register
// clamped to 1..MAX_POSITIONS. the input channel (in_valid_i / in_stall_o)
// takes one word: cmd 0 sets each position to its index, cmd 1 adds amount
// (saturating) to positions lo..hi, cmd 2 returns one plus the largest
// position whose value is below amount, or 1 if none. every word gives one
// output word on out_valid_o / out_stall_i; position is 0 except for search.
// one word is worked at a time; the entries live in one ram with a
// registered read, so init writes each position, add reads then writes each
// position in range, and search reads then checks from n downward to a hit.
// the finished answer waits in an output register; while the receiver
// stalls the next word is still taken and worked, only its answer waits.
// reset clears control and sets size to 1024; ram contents are undefined
// until the first init. write size only while idle.
module range_add_min_search_tree import ramst_pkg::*; #(
  parameter int unsigned MAX_POSITIONS = 1024
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [PosW-1:0]        cfg_data_i,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [CmdW-1:0]        cmd_i,
  input  logic [PosW-1:0]        lo_i,
  input  logic [PosW-1:0]        hi_i,
  input  logic signed [AmtW-1:0] amount_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [PosW-1:0]        position_o
);

  ramst_ctl_t ctl;
  ramst_sts_t sts;

  ramst_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  ramst_dp #(.MaxPositions(MAX_POSITIONS)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd_i),
    .lo_i        (lo_i),
    .hi_i        (hi_i),
    .amount_i    (amount_i),
    .ctl_i       (ctl),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .position_o  (position_o)
  );

endmodule

// ----- rtl/ramst_ram.sv -----
// ramst_ram: generic single write port, single read port ram, registered read
// no dependencies
module ramst_ram #(
  parameter int unsigned Width = 14,
  parameter int unsigned Depth = 1025
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/ramst_ctrl.sv -----
// ramst_ctrl: sequencer for init, range add and threshold search
// depends on ramst_pkg
module ramst_ctrl import ramst_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  ramst_sts_t sts_i,
  output ramst_ctl_t ctl_o
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_DISP  = 8'b0000_0010,
    S_INIT  = 8'b0000_0100,
    S_ADDRD = 8'b0000_1000,
    S_ADDWR = 8'b0001_0000,
    S_SRRD  = 8'b0010_0000,
    S_SRCHK = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    ctl_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          ctl_o.load = 1'b1;
          state_d    = S_DISP;
        end
      end
      S_DISP: begin
        unique case (sts_i.cmd)
          CMD_INIT:   state_d = S_INIT;
          CMD_ADD:    state_d = sts_i.empty ? S_DONE : S_ADDRD;
          CMD_SEARCH: state_d = S_SRRD;
          default:    state_d = S_DONE;
        endcase
      end
      S_INIT: begin
        ctl_o.wr = 1'b1;
        if (sts_i.at_end) begin
          state_d = S_DONE;
        end else begin
          ctl_o.step_up = 1'b1;
        end
      end
      S_ADDRD: state_d = S_ADDWR;
      S_ADDWR: begin
        ctl_o.wr = 1'b1;
        if (sts_i.at_end) begin
          state_d = S_DONE;
        end else begin
          ctl_o.step_up = 1'b1;
          state_d       = S_ADDRD;
        end
      end
      S_SRRD: state_d = S_SRCHK;
      S_SRCHK: begin
        priority if (sts_i.hit) begin
          ctl_o.set_hit = 1'b1;
          state_d       = S_DONE;
        end else if (sts_i.at_end) begin
          ctl_o.set_miss = 1'b1;
          state_d        = S_DONE;
        end else begin
          ctl_o.step_dn = 1'b1;
          state_d       = S_SRRD;
        end
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          ctl_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- rtl/ramst_dp.sv -----
// ramst_dp: size register, pointer, value memory, saturating adder, compare
// and output register; depends on ramst_pkg and ramst_ram
module ramst_dp import ramst_pkg::*; #(
  parameter int unsigned MaxPositions = 1024
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [PosW-1:0]        cfg_data_i,
  input  logic [CmdW-1:0]        cmd_i,
  input  logic [PosW-1:0]        lo_i,
  input  logic [PosW-1:0]        hi_i,
  input  logic signed [AmtW-1:0] amount_i,
  input  ramst_ctl_t             ctl_i,
  output ramst_sts_t             sts_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [PosW-1:0]        position_o
);

  localparam int unsigned AW = $clog2(MaxPositions + 1);
  localparam int unsigned NW = (AW > PosW) ? AW : PosW;

  logic [PosW-1:0]        size_q;
  cmd_e                   cmd_q;
  logic signed [AmtW-1:0] amt_q;
  logic [AW-1:0]          ptr_q, end_q;
  logic                   empty_q;
  logic [PosW-1:0]        ans_q, pos_q;
  logic                   out_valid_q;

  logic [NW-1:0]   sz, n_w, lo_w, hi_w, lo_e, hi_e;
  logic [AW-1:0]   n;
  logic [NW:0]     p1;
  logic [ValW-1:0] rdata, wdata, init_val, add_val;
  logic signed [ValW:0] sum;

  // clamp size to 1..MaxPositions
  always_comb begin
    sz = NW'(size_q);
    if (sz == '0) begin
      n_w = NW'(1);
    end else if (sz > NW'(MaxPositions)) begin
      n_w = NW'(MaxPositions);
    end else begin
      n_w = sz;
    end
    n    = AW'(n_w);
    lo_w = NW'(lo_i);
    hi_w = NW'(hi_i);
    lo_e = (lo_w == '0) ? NW'(1) : lo_w;
    hi_e = (hi_w > n_w) ? n_w : hi_w;
  end

  always_comb begin
    init_val = (32'(ptr_q) > 32'(ValMax)) ? ValW'(ValMax) : ValW'(ptr_q);
    sum = {rdata[ValW-1], rdata} + {{(ValW+1-AmtW){amt_q[AmtW-1]}}, amt_q};
    priority if (sum > (ValW+1)'(ValMax)) begin
      add_val = ValW'(ValMax);
    end else if (sum < $signed((ValW+1)'(ValMin))) begin
      add_val = ValW'(ValMin);
    end else begin
      add_val = sum[ValW-1:0];
    end
    wdata = (cmd_q == CMD_INIT) ? init_val : add_val;
    p1    = (NW+1)'(ptr_q) + (NW+1)'(1);
  end

  ramst_ram #(.Width(ValW), .Depth(MaxPositions + 1)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ctl_i.wr),
    .waddr_i (ptr_q),
    .wdata_i (wdata),
    .raddr_i (ptr_q),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      cmd_q   <= cmd_e'(cmd_i);
      amt_q   <= amount_i;
      empty_q <= (lo_e > hi_e);
      unique case (cmd_e'(cmd_i))
        CMD_INIT: begin
          ptr_q <= AW'(1);
          end_q <= n;
        end
        CMD_ADD: begin
          ptr_q <= AW'(lo_e);
          end_q <= AW'(hi_e);
        end
        default: begin
          ptr_q <= n;
          end_q <= AW'(1);
        end
      endcase
    end else if (ctl_i.step_up) begin
      ptr_q <= ptr_q + AW'(1);
    end else if (ctl_i.step_dn) begin
      ptr_q <= ptr_q - AW'(1);
    end
    priority if (ctl_i.load) begin
      ans_q <= '0;
    end else if (ctl_i.set_hit) begin
      ans_q <= p1[PosW-1:0];
    end else if (ctl_i.set_miss) begin
      ans_q <= PosW'(1);
    end
    if (ctl_i.out_load) begin
      pos_q <= ans_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q      <= PosW'(1024);
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        size_q <= cfg_data_i;
      end
      if (ctl_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.cmd      = cmd_q;
  assign sts_o.empty    = empty_q;
  assign sts_o.at_end   = (ptr_q == end_q);
  assign sts_o.hit      = ($signed(rdata) < $signed({amt_q[AmtW-1], amt_q}));
  assign sts_o.out_free = !out_valid_q || !out_stall_i;
  assign out_valid_o    = out_valid_q;
  assign position_o     = pos_q;

endmodule
